// File: design/dtq_pkg.sv
package dtq_pkg;

    localparam int ID_W   = 4;
    localparam int TIME_W = 63;
    localparam int CNT_OW = 5;   // width of the count fields in a result beat

    // operation select, carried on the input tuser
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_POLL   = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] wakeup;
    } entry_t;

endpackage

// File: design/dtq_store.sv
module dtq_store #(
    parameter int DEPTH = 16,
    parameter int PTR_W = 4
) (
    input  logic               clk,
    input  logic               we,
    input  logic [PTR_W-1:0]   waddr,
    input  dtq_pkg::entry_t    wdata,
    input  logic [PTR_W-1:0]   raddr,
    output dtq_pkg::entry_t    rdata
);

    dtq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: design/deadline_timer_queue.sv
// deadline timer queue: holds up to DEPTH (task id, wake-up time) pairs sorted by wake-up
// time, equal times in arrival order. each input beat carries one operation in tuser:
// insert, remove every entry of an id, or poll the head against the current time. each
// accepted beat yields exactly one result beat. the entries live in a circular buffer in a
// single memory with one write and one registered read port, so the work is paced by that
// read port: a poll reads the head, an insert walks back from the tail past every held
// entry with a later wake-up time (those entries slide back one place), a remove reads
// every held entry (the survivors are compacted toward the head), and an unused mode or
// an insert refused by a full queue goes straight to its result.
// a full queue refuses an insert and flags overflow. one operation is in flight at a time;
// the next beat is taken as soon as the previous one has its result registered, even if
// that result still waits on m_axis_tready; an operation that finishes while that beat
// still waits holds in its last cycle until the beat is taken. no memory clearing is
// needed after reset.
module deadline_timer_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // task_id, time_us, zero pad
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // expired, out_task_id, out_wakeup_us, overflow,
                                        // removed_count, occupancy, zero pad
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_RM_RD,
        ST_RM_CHK,
        ST_POLL_CHK,
        ST_FIN
    } state_t;

    // control
    state_t                  state_reg,   state_next;
    logic [PTR_W-1:0]        head_reg,    head_next;
    logic [CNT_W-1:0]        count_reg,   count_next;
    logic [CNT_W-1:0]        idx_reg,     idx_next;     // insert slot / remove read index
    logic [CNT_W-1:0]        wr_reg,      wr_next;      // remove write index
    logic                    out_valid_reg, out_valid_next;

    // operation operands
    logic [dtq_pkg::ID_W-1:0]   op_id_reg,   op_id_next;
    logic [dtq_pkg::TIME_W-1:0] op_time_reg, op_time_next;

    // result staging
    logic                       res_exp_reg,  res_exp_next;
    logic [dtq_pkg::ID_W-1:0]   res_id_reg,   res_id_next;
    logic [dtq_pkg::TIME_W-1:0] res_time_reg, res_time_next;
    logic                       res_ovf_reg,  res_ovf_next;
    logic [CNT_W-1:0]           res_rm_reg,   res_rm_next;

    // output beat
    logic                       out_exp_reg,  out_exp_next;
    logic [dtq_pkg::ID_W-1:0]   out_id_reg,   out_id_next;
    logic [dtq_pkg::TIME_W-1:0] out_time_reg, out_time_next;
    logic                       out_ovf_reg,  out_ovf_next;
    logic [dtq_pkg::CNT_OW-1:0] out_rm_reg,   out_rm_next;
    logic [dtq_pkg::CNT_OW-1:0] out_occ_reg,  out_occ_next;

    // memory port
    logic                    mem_we;
    logic [CNT_W-1:0]        wr_log;
    logic [CNT_W-1:0]        rd_log;
    dtq_pkg::entry_t         mem_wdata;
    dtq_pkg::entry_t         mem_rdata;
    dtq_pkg::entry_t         new_entry;

    logic                    in_beat;

    // queue position to buffer address
    function automatic logic [PTR_W-1:0] to_phys(input logic [PTR_W-1:0] h,
                                                 input logic [CNT_W-1:0] i);
        logic [SUM_W-1:0] s;
        s = SUM_W'(h) + SUM_W'(i);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign new_entry     = '{id: op_id_reg, wakeup: op_time_reg};

    dtq_store #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (to_phys(head_reg, wr_log)),
        .wdata (mem_wdata),
        .raddr (to_phys(head_reg, rd_log)),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        wr_next        = wr_reg;
        out_valid_next = out_valid_reg;
        op_id_next     = op_id_reg;
        op_time_next   = op_time_reg;
        res_exp_next   = res_exp_reg;
        res_id_next    = res_id_reg;
        res_time_next  = res_time_reg;
        res_ovf_next   = res_ovf_reg;
        res_rm_next    = res_rm_reg;
        out_exp_next   = out_exp_reg;
        out_id_next    = out_id_reg;
        out_time_next  = out_time_reg;
        out_ovf_next   = out_ovf_reg;
        out_rm_next    = out_rm_reg;
        out_occ_next   = out_occ_reg;
        mem_we         = 1'b0;
        wr_log         = idx_reg;
        rd_log         = '0;
        mem_wdata      = new_entry;

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // head is read speculatively for a poll
                rd_log = '0;
                if (in_beat)
                begin
                    op_id_next    = s_axis_tdata[3:0];
                    op_time_next  = s_axis_tdata[66:4];
                    res_exp_next  = 1'b0;
                    res_id_next   = '0;
                    res_time_next = '0;
                    res_ovf_next  = 1'b0;
                    res_rm_next   = '0;
                    idx_next      = '0;
                    wr_next       = '0;
                    case (s_axis_tuser)
                        dtq_pkg::MODE_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_ovf_next = 1'b1;
                                state_next   = ST_FIN;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        dtq_pkg::MODE_REMOVE:
                        begin
                            state_next = ST_RM_RD;
                        end
                        dtq_pkg::MODE_POLL:
                        begin
                            state_next = (count_reg == '0) ? ST_FIN : ST_POLL_CHK;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    rd_log     = idx_reg - 1'b1;
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP:
            begin
                mem_we = 1'b1;
                if (mem_rdata.wakeup > op_time_reg)
                begin
                    // later entry slides back one place
                    mem_wdata  = mem_rdata;
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_FIN;
                end
            end

            ST_RM_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_rm_next = count_reg - wr_reg;
                    count_next  = wr_reg;
                    state_next  = ST_FIN;
                end
                else
                begin
                    rd_log     = idx_reg;
                    state_next = ST_RM_CHK;
                end
            end

            ST_RM_CHK:
            begin
                wr_log = wr_reg;
                if (mem_rdata.id != op_id_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    wr_next   = wr_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_RM_RD;
            end

            ST_POLL_CHK:
            begin
                if (mem_rdata.wakeup <= op_time_reg)
                begin
                    res_exp_next  = 1'b1;
                    res_id_next   = mem_rdata.id;
                    res_time_next = mem_rdata.wakeup;
                    head_next     = to_phys(head_reg, CNT_W'(1));
                    count_next    = count_reg - 1'b1;
                end
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_exp_next   = res_exp_reg;
                    out_id_next    = res_id_reg;
                    out_time_next  = res_time_reg;
                    out_ovf_next   = res_ovf_reg;
                    out_rm_next    = dtq_pkg::CNT_OW'(res_rm_reg);
                    out_occ_next   = dtq_pkg::CNT_OW'(count_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
            op_id_reg     <= '0;
            op_time_reg   <= '0;
            res_exp_reg   <= 1'b0;
            res_id_reg    <= '0;
            res_time_reg  <= '0;
            res_ovf_reg   <= 1'b0;
            res_rm_reg    <= '0;
            out_exp_reg   <= 1'b0;
            out_id_reg    <= '0;
            out_time_reg  <= '0;
            out_ovf_reg   <= 1'b0;
            out_rm_reg    <= '0;
            out_occ_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
            op_id_reg     <= op_id_next;
            op_time_reg   <= op_time_next;
            res_exp_reg   <= res_exp_next;
            res_id_reg    <= res_id_next;
            res_time_reg  <= res_time_next;
            res_ovf_reg   <= res_ovf_next;
            res_rm_reg    <= res_rm_next;
            out_exp_reg   <= out_exp_next;
            out_id_reg    <= out_id_next;
            out_time_reg  <= out_time_next;
            out_ovf_reg   <= out_ovf_next;
            out_rm_reg    <= out_rm_next;
            out_occ_reg   <= out_occ_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_occ_reg, out_rm_reg, out_ovf_reg,
                            out_time_reg, out_id_reg, out_exp_reg};

endmodule

// File: design/dtq_checker.sv
module dtq_checker #(
    parameter int DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // no pop reported means id and wake-up are zero
    a_no_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[67:1] == '0)
        else $error("popped fields set without expired");

    // a refused insert leaves a full queue
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[68] |-> m_axis_tdata[78:74] == 5'(DEPTH))
        else $error("overflow with queue not full");

    // only one kind of outcome per beat
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[73:69] != '0 |-> !m_axis_tdata[0] && !m_axis_tdata[68])
        else $error("remove count mixed with pop or overflow");

endmodule

bind deadline_timer_queue dtq_checker #(.DEPTH(DEPTH)) u_dtq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int QDEPTH = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_OPS = 1700;
    localparam int CALM_OPS = 200;        // tail of the run with no idling
    localparam int DRAIN_CYCLES = 40;     // idle time after the last reply, for stray beats
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [62:0] TIME_MAX = {63{1'b1}};

    // input beat layout, lowest bits first: task_id, time_us, zero pad
    typedef struct packed {
        logic [4:0]                 pad;
        logic [dtq_pkg::TIME_W-1:0] time_us;
        logic [dtq_pkg::ID_W-1:0]   task_id;
    } op_beat_t;

    // result beat layout, lowest bits first: expired, out_task_id,
    // out_wakeup_us, overflow, removed_count, occupancy, zero pad
    typedef struct packed {
        logic                       pad;
        logic [dtq_pkg::CNT_OW-1:0] occupancy;
        logic [dtq_pkg::CNT_OW-1:0] removed_count;
        logic                       overflow;
        logic [dtq_pkg::TIME_W-1:0] out_wakeup_us;
        logic [dtq_pkg::ID_W-1:0]   out_task_id;
        logic                       expired;
    } result_beat_t;

    // shadow of the sorted queue plus the replies it predicts
    class deadline_board;
        logic [dtq_pkg::ID_W-1:0]   slot_id [QDEPTH];
        logic [dtq_pkg::TIME_W-1:0] slot_time [QDEPTH];
        int unsigned       held;
        result_beat_t      op_replies[$];
        int unsigned       mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void apply_op(logic [1:0] mode, logic [dtq_pkg::ID_W-1:0] id,
                               logic [dtq_pkg::TIME_W-1:0] t);
            result_beat_t r;
            int unsigned pos;
            int unsigned k;
            int unsigned kept;
            r = '0;
            case (mode)
                dtq_pkg::MODE_INSERT:
                begin
                    if (held >= QDEPTH)
                        r.overflow = 1'b1;
                    else
                    begin
                        // equal times go behind those already held
                        pos = 0;
                        while (pos < held && slot_time[pos] <= t)
                            pos++;
                        for (k = held; k > pos; k--)
                        begin
                            slot_id[k] = slot_id[k-1];
                            slot_time[k] = slot_time[k-1];
                        end
                        slot_id[pos] = id;
                        slot_time[pos] = t;
                        held++;
                    end
                end
                dtq_pkg::MODE_REMOVE:
                begin
                    kept = 0;
                    for (k = 0; k < held; k++)
                    begin
                        if (slot_id[k] != id)
                        begin
                            slot_id[kept] = slot_id[k];
                            slot_time[kept] = slot_time[k];
                            kept++;
                        end
                    end
                    r.removed_count = dtq_pkg::CNT_OW'(held - kept);
                    held = kept;
                end
                dtq_pkg::MODE_POLL:
                begin
                    if (held > 0 && slot_time[0] <= t)
                    begin
                        r.expired = 1'b1;
                        r.out_task_id = slot_id[0];
                        r.out_wakeup_us = slot_time[0];
                        for (k = 1; k < held; k++)
                        begin
                            slot_id[k-1] = slot_id[k];
                            slot_time[k-1] = slot_time[k];
                        end
                        held--;
                    end
                end
                default:
                begin
                end
            endcase
            r.occupancy = dtq_pkg::CNT_OW'(held);
            op_replies.push_back(r);
        endfunction

        function void check_result(logic [79:0] beat);
            result_beat_t got;
            result_beat_t want;
            got = result_beat_t'(beat);
            if (op_replies.size() == 0)
            begin
                $error("result beat with nothing outstanding: %h", beat);
                mismatches++;
                return;
            end
            want = op_replies.pop_front();
            if (got.expired !== want.expired)
            begin
                $error("expired: expected %0d, got %0d", want.expired, got.expired);
                mismatches++;
            end
            if (got.out_task_id !== want.out_task_id)
            begin
                $error("out_task_id: expected %0d, got %0d", want.out_task_id, got.out_task_id);
                mismatches++;
            end
            if (got.out_wakeup_us !== want.out_wakeup_us)
            begin
                $error("out_wakeup_us: expected %0d, got %0d",
                       want.out_wakeup_us, got.out_wakeup_us);
                mismatches++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
                mismatches++;
            end
            if (got.removed_count !== want.removed_count)
            begin
                $error("removed_count: expected %0d, got %0d",
                       want.removed_count, got.removed_count);
                mismatches++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;    // task_id, time_us, zero pad
    logic [1:0]  s_axis_tuser;    // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;    // expired, out_task_id, out_wakeup_us, overflow,
                                  // removed_count, occupancy, zero pad

    deadline_board board;
    bit            src_idle;      // random gaps between input beats
    bit            sink_stall;    // random back-pressure on results
    logic [62:0]   now_us;        // running notion of current time
    logic [62:0]   last_wakeup;   // reused to provoke equal-time ties
    int unsigned   cycle_count;

    deadline_timer_queue #(
        .DEPTH(QDEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // present one operation and hold it until the block takes the beat;
    // tvalid stays high into the next call when no gap is drawn
    task automatic send_op(input logic [1:0] mode, input logic [dtq_pkg::ID_W-1:0] id,
                           input logic [dtq_pkg::TIME_W-1:0] t);
        op_beat_t beat;
        beat = '0;
        beat.task_id = id;
        beat.time_us = t;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.apply_op(mode, id, t);
    endtask

    function automatic logic [62:0] wide_time();
        return 63'({$urandom, $urandom});
    endfunction

    // one random operation; fill phases lean on inserts, drain phases on polls
    task automatic random_op(input bit filling, input int unsigned id_top);
        int unsigned roll;
        int unsigned pick;
        logic [dtq_pkg::ID_W-1:0] id;
        logic [62:0] t;
        roll = $urandom_range(0, 99);
        id = dtq_pkg::ID_W'($urandom_range(0, id_top));
        pick = $urandom_range(0, 19);
        if (roll < (filling ? 62 : 35))
        begin
            if (pick < 14)
                t = now_us + 63'($urandom_range(0, 400));
            else if (pick < 16)
                t = last_wakeup;
            else if (pick < 18)
                t = wide_time();
            else if (pick < 19)
                t = TIME_MAX;
            else
                t = '0;
            last_wakeup = t;
            send_op(dtq_pkg::MODE_INSERT, id, t);
        end
        else if (roll < (filling ? 72 : 45))
            send_op(dtq_pkg::MODE_REMOVE, id, wide_time());
        else if (roll < (filling ? 75 : 48))
            send_op(MODE_UNUSED, id, wide_time());
        else
        begin
            now_us = now_us + 63'($urandom_range(0, 80));
            if (pick < 16)
                t = now_us;
            else if (pick < 18)
                t = TIME_MAX;
            else
                t = wide_time();
            send_op(dtq_pkg::MODE_POLL, id, t);
        end
    endtask

    // result sink with random stall bursts
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (sink_stall && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("deadline_timer_queue test failed");
        $finish;
    end

    initial
    begin
        int unsigned n;
        bit filling;
        int unsigned id_top;
        board = new();
        src_idle = 1'b1;
        sink_stall = 1'b1;
        now_us = '0;
        last_wakeup = '0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= dtq_pkg::MODE_INSERT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue cases first
        send_op(dtq_pkg::MODE_POLL, 4'd9, TIME_MAX);      // poll on empty queue
        send_op(MODE_UNUSED, 4'hF, TIME_MAX);             // unused mode value
        send_op(dtq_pkg::MODE_REMOVE, 4'd7, '0);          // remove on empty queue
        // extreme times and a tie
        send_op(dtq_pkg::MODE_INSERT, 4'hF, TIME_MAX);
        send_op(dtq_pkg::MODE_INSERT, 4'h0, '0);
        send_op(dtq_pkg::MODE_INSERT, 4'd5, 63'd100);
        send_op(dtq_pkg::MODE_INSERT, 4'd6, 63'd100);     // ties go behind id 5
        send_op(dtq_pkg::MODE_POLL, 4'd0, 63'd50);        // pops the zero-time entry
        send_op(dtq_pkg::MODE_POLL, 4'd0, 63'd99);        // head not yet due
        send_op(dtq_pkg::MODE_REMOVE, 4'd5, '0);
        // fill to the brim, with some equal times among them
        for (n = 0; n < QDEPTH - 2; n++)
            send_op(dtq_pkg::MODE_INSERT, 4'd3, 63'(200 + (n / 2) * 10));
        send_op(dtq_pkg::MODE_INSERT, 4'd8, 63'd150);     // refused, queue full
        send_op(dtq_pkg::MODE_REMOVE, 4'd3, TIME_MAX);    // sweeps most of the queue
        send_op(dtq_pkg::MODE_POLL, 4'hA, TIME_MAX);

        // random part: alternating fill and drain phases, some with few ids so
        // that removes hit many entries at once
        filling = 1'b1;
        id_top = 15;
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 120 == 0)
            begin
                filling = ~filling;
                id_top = ($urandom_range(0, 2) == 0) ? 1 : 15;
            end
            if (n == RANDOM_OPS - CALM_OPS)
            begin
                src_idle = 1'b0;
                sink_stall = 1'b0;
            end
            random_op(filling, id_top);
        end
        s_axis_tvalid <= 1'b0;

        // let every reply drain, then give the block time for stray beats
        while (board.op_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("deadline_timer_queue test passed");
        else
            $display("deadline_timer_queue test failed");
        $finish;
    end

endmodule

// File: deadline_timer_queue.f
design/dtq_pkg.sv
design/dtq_store.sv
design/deadline_timer_queue.sv
design/dtq_checker.sv
tb/sv/tb.sv
